@@ rtl/core/nmea_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmea_pkg
// shared widths, character codes and slot tables of the rmc field extractor
// ----------------------------------------------------------------------------
package nmea_pkg;

    localparam int SENTENCE_CAPACITY_DEF = 128;
    localparam int FIELD_CHARS_DEF       = 12;

    localparam int CHAR_W  = 8;
    localparam int CODE_W  = 3;
    localparam int IDX_W   = 4;
    localparam int POS_W   = 8;
    localparam int COMMA_W = 3;
    localparam int SLOT_W  = 3;

    localparam int NUM_SLOTS = 5;

    localparam logic [CHAR_W-1:0] CH_DOLLAR  = 8'h24;
    localparam logic [CHAR_W-1:0] CH_M       = 8'h4D;
    localparam logic [CHAR_W-1:0] CH_C       = 8'h43;
    localparam logic [CHAR_W-1:0] CH_NL      = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_COMMA   = 8'h2C;
    localparam logic [CHAR_W-1:0] CH_A       = 8'h41;
    localparam logic [CHAR_W-1:0] CH_V       = 8'h56;

    localparam logic [COMMA_W-1:0] COMMA_MAX    = 3'd7;
    localparam logic [COMMA_W-1:0] COMMA_STATUS = 3'd2;
    localparam logic [COMMA_W-1:0] COMMA_STAT_CLOSED = 3'd3;

    localparam logic [2:0] MARKS_RMC = 3'b111;

    localparam logic [CODE_W-1:0] CODE_TERM = 3'd0;

    localparam logic [SLOT_W-1:0] NO_SLOT = 3'd7;

    // field number of each capture slot
    function automatic logic [CODE_W-1:0] slot_field(input logic [SLOT_W-1:0] s);
        case (s)
            3'd0:    slot_field = 3'd1;
            3'd1:    slot_field = 3'd3;
            3'd2:    slot_field = 3'd4;
            3'd3:    slot_field = 3'd5;
            3'd4:    slot_field = 3'd6;
            default: slot_field = CODE_TERM;
        endcase
    endfunction

    // character capacity of each slot
    function automatic logic [IDX_W-1:0] slot_cap(input logic [SLOT_W-1:0] s,
                                                  input int fc);
        case (s)
            3'd2, 3'd4: slot_cap = 4'd1;
            default:    slot_cap = IDX_W'(fc);
        endcase
    endfunction

    // first store entry of each slot
    function automatic logic [7:0] slot_base(input logic [SLOT_W-1:0] s,
                                            input int fc);
        case (s)
            3'd0:    slot_base = 8'd0;
            3'd1:    slot_base = 8'(fc);
            3'd2:    slot_base = 8'(2 * fc);
            3'd3:    slot_base = 8'(2 * fc + 1);
            3'd4:    slot_base = 8'(3 * fc + 1);
            default: slot_base = 8'd0;
        endcase
    endfunction

    // slot that collects the characters after a given comma count
    function automatic logic [SLOT_W-1:0] slot_of(input logic [COMMA_W-1:0] c);
        case (c)
            3'd1:    slot_of = 3'd0;
            3'd3:    slot_of = 3'd1;
            3'd4:    slot_of = 3'd2;
            3'd5:    slot_of = 3'd3;
            3'd6:    slot_of = 3'd4;
            default: slot_of = NO_SLOT;
        endcase
    endfunction

endpackage

@@ rtl/core/nmea_rmc_sentence_field_extractor_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmea_rmc_sentence_field_extractor_unit
// parses serial nmea bytes, captures rmc fields 1 and 3 to 6 in a field ram and
// streams out time, latitude, n/s, longitude, e/w and a terminator at line end
// ----------------------------------------------------------------------------
// input: an ordinary byte is absorbed in the cycle it is accepted, one byte
//   per cycle while s_tready is high; after an rmc line end, empty leading
//   slots are skipped, then the first result waits for a ram read and a load
// output: each character takes a ram read (ST_RD) then an output load (ST_LOAD),
//   each slot takes an advance and the terminator its own load; an output
//   stall holds ST_LOAD and the terminator; input is held off for the whole burst
// reset: aresetn low clears sentence state, usable flag and output valid;
//   field ram contents are not cleared, only entries below a length are read
// ----------------------------------------------------------------------------
module nmea_rmc_sentence_field_extractor_unit
    import nmea_pkg::*;
#(
    parameter int SENTENCE_CAPACITY = SENTENCE_CAPACITY_DEF,
    parameter int FIELD_CHARS       = FIELD_CHARS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input request: rx_byte [7:0]
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,
    // result request: field_code [2:0], char_code [10:3], char_index [14:11],
    // fix_usable [15], format_error [16], zero [23:17]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,
    output logic        m_tlast
);

    localparam int STORE_DEPTH = 3 * FIELD_CHARS + 2;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    localparam logic [POS_W-1:0]  CAP_POS = POS_W'(SENTENCE_CAPACITY);
    localparam logic [SLOT_W-1:0] SLOT_END = SLOT_W'(NUM_SLOTS);

    // sequencer codes
    localparam logic [1:0] ST_IDLE = 2'd0;  // taking input bytes
    localparam logic [1:0] ST_RD   = 2'd1;  // pick next character, issue ram read
    localparam logic [1:0] ST_LOAD = 2'd2;  // ram data ready, load output register

    // ------------------------------------------------------------------------
    // state registers
    // ------------------------------------------------------------------------
    logic [1:0]         state_reg,  state_next;
    logic [POS_W-1:0]   pos_reg,    pos_next;
    logic [2:0]         marks_reg,  marks_next;
    logic [COMMA_W-1:0] comma_reg,  comma_next;
    logic [CHAR_W-1:0]  status_reg, status_next;
    logic               usable_reg, usable_next;
    logic               ferr_reg,   ferr_next;
    logic [IDX_W-1:0]   lens_reg    [NUM_SLOTS];
    logic [IDX_W-1:0]   lens_next   [NUM_SLOTS];
    logic [SLOT_W-1:0]  slot_reg,   slot_next;
    logic [IDX_W-1:0]   idx_reg,    idx_next;

    // output register
    logic               m_valid_reg, m_valid_next;
    logic [23:0]        m_data_reg,  m_data_next;
    logic               m_last_reg,  m_last_next;

    // field ram ports
    logic              ram_wr_en;
    logic [ADDR_W-1:0] ram_wr_addr;
    logic              ram_rd_en;
    logic [ADDR_W-1:0] ram_rd_addr;
    logic [CHAR_W-1:0] ram_rd_data;

    nmea_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (STORE_DEPTH)
    ) u_field_ram (
        .clk     (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (s_tdata),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // ------------------------------------------------------------------------
    // decode of the incoming byte
    // ------------------------------------------------------------------------
    logic               in_fire;
    logic               is_dollar;
    logic [POS_W-1:0]   pos_eff;
    logic [2:0]         marks_eff;
    logic [COMMA_W-1:0] comma_eff;
    logic [CHAR_W-1:0]  status_eff;
    logic [SLOT_W-1:0]  slot_in;
    logic [SLOT_W-1:0]  len_sel;
    logic [IDX_W-1:0]   len_rd;
    logic [IDX_W-1:0]   len_eff;
    logic               out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    // a '$' restarts the sentence before the byte itself is handled
    assign is_dollar  = (s_tdata == CH_DOLLAR);
    assign pos_eff    = is_dollar ? '0 : pos_reg;
    assign marks_eff  = is_dollar ? '0 : marks_reg;
    assign comma_eff  = is_dollar ? '0 : comma_reg;
    assign status_eff = is_dollar ? '0 : status_reg;
    assign slot_in    = slot_of(comma_eff);

    // one shared read of the length table: input slot while idle, else the
    // slot being emitted
    always_comb begin
        len_sel = (state_reg == ST_IDLE) ? slot_in : slot_reg;
        if (len_sel >= SLOT_END) begin
            len_sel = '0;
        end
    end
    assign len_rd  = lens_reg[len_sel];
    assign len_eff = is_dollar ? '0 : len_rd;

    // ------------------------------------------------------------------------
    // next-state logic
    // ------------------------------------------------------------------------
    always_comb begin
        state_next   = state_reg;
        pos_next     = pos_reg;
        marks_next   = marks_reg;
        comma_next   = comma_reg;
        status_next  = status_reg;
        usable_next  = usable_reg;
        ferr_next    = ferr_reg;
        lens_next    = lens_reg;
        slot_next    = slot_reg;
        idx_next     = idx_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;
        ram_wr_en    = 1'b0;
        ram_wr_addr  = '0;
        ram_rd_en    = 1'b0;
        ram_rd_addr  = '0;

        if (m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    if (is_dollar) begin
                        pos_next    = '0;
                        marks_next  = '0;
                        comma_next  = '0;
                        status_next = '0;
                        for (int i = 0; i < NUM_SLOTS; i++) begin
                            lens_next[i] = '0;
                        end
                    end
                    // bytes past capacity are dropped, line end included
                    if (pos_eff < CAP_POS) begin
                        pos_next = pos_eff + 1'b1;

                        // header marks at byte positions 0, 4 and 5
                        if (pos_eff == 8'd0) begin
                            marks_next[0] = is_dollar;
                        end else if (pos_eff == 8'd4) begin
                            marks_next[1] = (s_tdata == CH_M);
                        end else if (pos_eff == 8'd5) begin
                            marks_next[2] = (s_tdata == CH_C);
                        end

                        if (s_tdata == CH_COMMA) begin
                            if (comma_eff < COMMA_MAX) begin
                                comma_next = comma_eff + 1'b1;
                                if (comma_next == COMMA_STATUS) begin
                                    status_next = '0;
                                end
                            end
                        end else if (s_tdata == CH_NL) begin
                            if (marks_next == MARKS_RMC) begin
                                ferr_next = (comma_eff < COMMA_MAX);
                                // status applies only once field 2 is closed
                                if (comma_eff >= COMMA_STAT_CLOSED) begin
                                    if (status_eff == CH_A) begin
                                        usable_next = 1'b1;
                                    end else if (status_eff == CH_V) begin
                                        usable_next = 1'b0;
                                    end
                                end
                                slot_next  = '0;
                                idx_next   = '0;
                                state_next = ST_RD;
                            end
                        end else if (comma_eff == COMMA_STATUS) begin
                            // first character of the status field wins
                            if (status_eff == '0) begin
                                status_next = s_tdata;
                            end
                        end else if (slot_in != NO_SLOT) begin
                            // overflow characters are dropped
                            if (len_eff < slot_cap(slot_in, FIELD_CHARS)) begin
                                ram_wr_en   = 1'b1;
                                ram_wr_addr = ADDR_W'(slot_base(slot_in, FIELD_CHARS))
                                            + ADDR_W'(len_eff);
                                lens_next[slot_in] = len_eff + 1'b1;
                            end
                        end
                    end
                end
            end

            ST_RD: begin
                if (slot_reg >= SLOT_END) begin
                    // all slots done: terminator, then a fresh sentence
                    if (out_free) begin
                        m_valid_next = 1'b1;
                        m_data_next  = {7'd0, ferr_reg, usable_reg, {IDX_W{1'b0}},
                                        {CHAR_W{1'b0}}, CODE_TERM};
                        m_last_next  = 1'b1;
                        pos_next     = '0;
                        marks_next   = '0;
                        comma_next   = '0;
                        status_next  = '0;
                        for (int i = 0; i < NUM_SLOTS; i++) begin
                            lens_next[i] = '0;
                        end
                        state_next   = ST_IDLE;
                    end
                end else if ((comma_reg > slot_field(slot_reg)) && (idx_reg < len_rd)) begin
                    // closed field with characters left to send
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = ADDR_W'(slot_base(slot_reg, FIELD_CHARS))
                                + ADDR_W'(idx_reg);
                    state_next  = ST_LOAD;
                end else begin
                    slot_next = slot_reg + 1'b1;
                    idx_next  = '0;
                end
            end

            ST_LOAD: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {7'd0, ferr_reg, usable_reg, idx_reg,
                                    ram_rd_data, slot_field(slot_reg)};
                    m_last_next  = 1'b0;
                    idx_next     = idx_reg + 1'b1;
                    state_next   = ST_RD;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pos_reg     <= '0;
            marks_reg   <= '0;
            comma_reg   <= '0;
            status_reg  <= '0;
            usable_reg  <= 1'b0;
            ferr_reg    <= 1'b0;
            slot_reg    <= '0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                lens_reg[i] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            pos_reg     <= pos_next;
            marks_reg   <= marks_next;
            comma_reg   <= comma_next;
            status_reg  <= status_next;
            usable_reg  <= usable_next;
            ferr_reg    <= ferr_next;
            slot_reg    <= slot_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
            lens_reg    <= lens_next;
        end
    end

    // output payload needs no reset
    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule

@@ rtl/core/nmea_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmea_ram
// generic single-port-write, single-port-read ram with registered read
// ----------------------------------------------------------------------------
module nmea_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 38,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
